// File: rtl/core/lbpc_pkg.sv
package lbpc_pkg;

    localparam int NUM_LEDS = 3;
    localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int MASK_LEDS = (NUM_LEDS < 3) ? NUM_LEDS : 3;
    localparam int PHASE_W = 11;

    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_SET_MODE   = 2'd1,
        ACT_SET_ENABLE = 2'd2,
        ACT_ALL_OFF    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        MODE_OFF           = 3'd0,
        MODE_SOLID         = 3'd1,
        MODE_BLINK_1HZ     = 3'd2,
        MODE_BLINK_HALF_HZ = 3'd3,
        MODE_BLINK_5HZ     = 3'd4,
        MODE_PULSE         = 3'd5
    } mode_t;

    localparam logic CFG_ON_LEVEL  = 1'b0;
    localparam logic CFG_PULSE_LEN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_TICK,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic                 capture;
        logic                 apply;
        logic                 tick_step;
        logic                 emit;
        logic [LED_IDX_W-1:0] led_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic out_full;
    } dp_status_t;

    // blink period in ms, 1 for modes that do not blink
    function automatic logic [PHASE_W-1:0] period_of(input mode_t mode);
        logic [PHASE_W-1:0] p;
        unique case (mode)
            MODE_BLINK_1HZ:     p = PHASE_W'(1000);
            MODE_BLINK_HALF_HZ: p = PHASE_W'(2000);
            MODE_BLINK_5HZ:     p = PHASE_W'(200);
            default:            p = PHASE_W'(1);
        endcase
        return p;
    endfunction

endpackage

// File: rtl/core/led_blink_pattern_controller_core.sv
// a mode, enable or all-off request is applied in the apply state and its result loaded in the emit state;
// a tick updates the leds in turn, one led per cycle through a shared update unit, before the emit state
// a new request is taken only in the idle state, once the previous result has been loaded
// a result still waiting in the output register holds the controller until taken
// reset: asynchronous active low; all leds off and unlit, timers zero, master enabled,
// on_level 1, pulse_length_ms 50
module led_blink_pattern_controller_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [1:0] led_index,
    input  logic [2:0] new_mode,
    input  logic       enable_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] lit_mask,
    output logic [7:0] drive_level,
    output logic [2:0] selected_mode,
    output logic       master_on
);
    import lbpc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign cfg_ready = 1'b1;

    lbpc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lbpc_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .led_index     (led_index),
        .new_mode      (new_mode),
        .enable_value  (enable_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lit_mask      (lit_mask),
        .drive_level   (drive_level),
        .selected_mode (selected_mode),
        .master_on     (master_on)
    );

endmodule

// File: rtl/core/lbpc_ctrl.sv
module lbpc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lbpc_pkg::dp_status_t sts,
    output lbpc_pkg::ctrl_cmd_t  cmd
);
    import lbpc_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [LED_IDX_W-1:0] cnt_reg, cnt_next;
    logic                 cnt_last;

    assign cnt_last = (cnt_reg == LED_IDX_W'(NUM_LEDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.led_sel = cnt_reg;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cnt_next = '0;
                if (sts.is_tick)
                begin
                    state_next = ST_TICK;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + LED_IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_emit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !sts.out_full)
        else $error("result loaded while output register still full");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_step |-> (32'(cnt_reg) < NUM_LEDS))
        else $error("led counter out of range");

    a_emit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after result");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.apply, cmd.tick_step, cmd.emit}))
        else $error("more than one datapath command at once");
`endif

endmodule

// File: rtl/core/lbpc_datapath.sv
module lbpc_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lbpc_pkg::ctrl_cmd_t  cmd,
    output lbpc_pkg::dp_status_t sts,
    input  logic [1:0]           action,
    input  logic [1:0]           led_index,
    input  logic [2:0]           new_mode,
    input  logic                 enable_value,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [9:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           lit_mask,
    output logic [7:0]           drive_level,
    output logic [2:0]           selected_mode,
    output logic                 master_on
);
    import lbpc_pkg::*;

    // captured request
    logic [1:0] action_reg;
    logic [1:0] idx_reg;
    logic [2:0] new_mode_reg;
    logic       enable_reg;

    // per-led state
    mode_t              mode_reg    [NUM_LEDS];
    logic [31:0]        elapsed_reg [NUM_LEDS];
    logic [PHASE_W-1:0] phase_reg   [NUM_LEDS];
    logic [NUM_LEDS-1:0] lit_reg;
    logic               master_reg;
    logic [7:0]         on_level_reg;
    logic [9:0]         pulse_len_reg;

    // result register
    logic       out_valid_reg;
    logic [2:0] lit_mask_reg;
    logic [7:0] drive_level_reg;
    logic [2:0] selected_mode_reg;
    logic       master_on_reg;

    logic                 sel_ok;
    logic [LED_IDX_W-1:0] sel_idx;
    logic [LED_IDX_W-1:0] rd_idx;
    mode_t                rd_mode;
    mode_t                wr_mode;
    logic                 wr_lit;
    logic [PHASE_W-1:0]   period;
    logic [31:0]          el_inc;
    logic [PHASE_W-1:0]   ph_cur;
    logic [PHASE_W-1:0]   ph_next;
    logic                 blink_on;
    logic                 is_blink;
    logic                 pulse_expire;
    logic [2:0]           mask;

    function automatic logic is_blink_mode(input mode_t m);
        return (m == MODE_BLINK_1HZ) || (m == MODE_BLINK_HALF_HZ) || (m == MODE_BLINK_5HZ);
    endfunction

    assign sel_ok  = (32'(idx_reg) < NUM_LEDS);
    assign sel_idx = sel_ok ? LED_IDX_W'(idx_reg) : '0;
    assign rd_idx  = cmd.tick_step ? cmd.led_sel : sel_idx;
    assign rd_mode = mode_reg[rd_idx];

    assign wr_mode = (new_mode_reg > 3'(MODE_PULSE)) ? MODE_OFF : mode_t'(new_mode_reg);
    assign wr_lit  = ((wr_mode == MODE_SOLID) || (wr_mode == MODE_PULSE)) && master_reg;

    // shared per-led tick unit
    assign period   = period_of(rd_mode);
    assign el_inc   = elapsed_reg[cmd.led_sel] + 32'd1;
    assign ph_cur   = phase_reg[cmd.led_sel];
    assign ph_next  = ((el_inc == 32'd0) || (ph_cur == period - PHASE_W'(1)))
                      ? '0 : ph_cur + PHASE_W'(1);
    assign blink_on = (ph_next < (period >> 1));
    assign is_blink = (rd_mode == MODE_BLINK_1HZ) || (rd_mode == MODE_BLINK_HALF_HZ)
                      || (rd_mode == MODE_BLINK_5HZ);
    assign pulse_expire = (rd_mode == MODE_PULSE) && lit_reg[cmd.led_sel]
                          && (el_inc > 32'(pulse_len_reg));

    always_comb
    begin
        mask = '0;
        for (int i = 0; i < MASK_LEDS; i++)
        begin
            mask[i] = lit_reg[i];
        end
    end

    assign sts.is_tick  = (action_reg == ACT_TICK);
    assign sts.out_full = out_valid_reg && out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= action;
            idx_reg      <= led_index;
            new_mode_reg <= new_mode;
            enable_reg   <= enable_value;
        end
        if (cmd.emit)
        begin
            lit_mask_reg      <= mask;
            drive_level_reg   <= (mask != 3'd0) ? on_level_reg : 8'd0;
            selected_mode_reg <= sel_ok ? 3'(rd_mode) : 3'(MODE_OFF);
            master_on_reg     <= master_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                mode_reg[i]    <= MODE_OFF;
                elapsed_reg[i] <= '0;
                phase_reg[i]   <= '0;
            end
            lit_reg       <= '0;
            master_reg    <= 1'b1;
            on_level_reg  <= 8'd1;
            pulse_len_reg <= 10'd50;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ON_LEVEL:  on_level_reg  <= cfg_data[7:0];
                    CFG_PULSE_LEN: pulse_len_reg <= cfg_data;
                    default:       ;
                endcase
            end

            if (cmd.apply)
            begin
                unique case (action_t'(action_reg))
                    ACT_SET_MODE:
                    begin
                        if (sel_ok)
                        begin
                            mode_reg[sel_idx]    <= wr_mode;
                            elapsed_reg[sel_idx] <= '0;
                            phase_reg[sel_idx]   <= '0;
                            if (wr_mode == MODE_OFF)
                            begin
                                lit_reg[sel_idx] <= 1'b0;
                            end
                            else if (!is_blink_mode(wr_mode))
                            begin
                                lit_reg[sel_idx] <= wr_lit;
                            end
                        end
                    end
                    ACT_SET_ENABLE:
                    begin
                        master_reg <= enable_reg;
                        if (!enable_reg)
                        begin
                            lit_reg <= '0;
                        end
                    end
                    ACT_ALL_OFF:
                    begin
                        for (int i = 0; i < NUM_LEDS; i++)
                        begin
                            mode_reg[i]    <= MODE_OFF;
                            elapsed_reg[i] <= '0;
                            phase_reg[i]   <= '0;
                        end
                        lit_reg <= '0;
                    end
                    default: ;
                endcase
            end

            if (cmd.tick_step)
            begin
                elapsed_reg[cmd.led_sel] <= el_inc;
                phase_reg[cmd.led_sel]   <= ph_next;
                if (is_blink)
                begin
                    lit_reg[cmd.led_sel] <= blink_on && master_reg;
                end
                else if (pulse_expire)
                begin
                    lit_reg[cmd.led_sel]  <= 1'b0;
                    mode_reg[cmd.led_sel] <= MODE_OFF;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign lit_mask      = lit_mask_reg;
    assign drive_level   = drive_level_reg;
    assign selected_mode = selected_mode_reg;
    assign master_on     = master_on_reg;

`ifndef ASSERT_OFF
    a_dark_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        !master_reg |-> (lit_reg == '0))
        else $error("led lit while master enable is off");

    a_level_needs_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (drive_level_reg != 8'd0)) |-> (lit_mask_reg != 3'd0))
        else $error("drive level reported with no led lit");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (selected_mode_reg <= 3'(MODE_PULSE)))
        else $error("reported mode out of range");
`endif

endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lbpc_pkg::*;

    localparam int RESET_CYCLES      = 9;
    localparam int SETTLE_CYCLES     = 10;
    localparam int LONG_HOLD_CYCLES  = 100;
    localparam int STUCK_LIMIT       = 2000;
    localparam int ITEMS_PER_PHASE   = 55;

    typedef struct packed {
        logic [2:0] lit_mask;
        logic [7:0] drive_level;
        logic [2:0] selected_mode;
        logic       master_on;
    } led_status_t;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [1:0] action        = 2'd0;
    logic [1:0] led_index     = 2'd0;
    logic [2:0] new_mode      = 3'd0;
    logic       enable_value  = 1'b0;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic       cfg_index     = 1'b0;
    logic [9:0] cfg_data      = 10'd0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [2:0] lit_mask;
    logic [7:0] drive_level;
    logic [2:0] selected_mode;
    logic       master_on;

    // led model state
    logic [31:0] now_ms;
    mode_t       led_mode_q [NUM_LEDS];
    logic [31:0] start_ms   [NUM_LEDS];
    logic        led_on     [NUM_LEDS];
    logic        master_q;
    logic [7:0]  on_level_q;
    logic [9:0]  pulse_len_q;

    led_status_t expected_status_q [$];
    int          error_count     = 0;
    int          requests_sent   = 0;
    int          results_checked = 0;
    int          stuck_cycles    = 0;
    int          sender_calm     = 0;
    int          receiver_calm   = 0;
    logic        sender_quiet    = 1'b0;
    logic        receiver_quiet  = 1'b0;
    logic        long_hold_req   = 1'b0;

    led_blink_pattern_controller_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .led_index     (led_index),
        .new_mode      (new_mode),
        .enable_value  (enable_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lit_mask      (lit_mask),
        .drive_level   (drive_level),
        .selected_mode (selected_mode),
        .master_on     (master_on)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic void store_mode(input int i, input logic [2:0] m);
        mode_t stored;
        stored = (m > MODE_PULSE) ? MODE_OFF : mode_t'(m);
        led_mode_q[i] = stored;
        start_ms[i] = now_ms;
        if (stored == MODE_OFF)
            led_on[i] = 1'b0;
        else if (stored == MODE_SOLID || stored == MODE_PULSE)
            led_on[i] = master_q;
    endfunction

    function automatic void advance_one_ms();
        logic [31:0] elapsed;
        now_ms = now_ms + 32'd1;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            elapsed = now_ms - start_ms[i];
            case (led_mode_q[i])
                MODE_BLINK_1HZ:     led_on[i] = master_q && ((elapsed % 32'd1000) < 32'd500);
                MODE_BLINK_HALF_HZ: led_on[i] = master_q && ((elapsed % 32'd2000) < 32'd1000);
                MODE_BLINK_5HZ:     led_on[i] = master_q && ((elapsed % 32'd200) < 32'd100);
                MODE_PULSE:
                begin
                    // an unlit pulse never expires
                    if (led_on[i] && elapsed > {22'd0, pulse_len_q})
                    begin
                        led_on[i] = 1'b0;
                        led_mode_q[i] = MODE_OFF;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic led_status_t predict_led_status(input action_t act, input logic [1:0] idx,
                                                       input logic [2:0] md, input logic en);
        led_status_t s;
        s = '0;
        case (act)
            ACT_TICK:     advance_one_ms();
            ACT_SET_MODE: if (idx < NUM_LEDS) store_mode(int'(idx), md);
            ACT_SET_ENABLE:
            begin
                master_q = en;
                if (!en)
                    for (int i = 0; i < NUM_LEDS; i++)
                        led_on[i] = 1'b0;
            end
            default:
                for (int i = 0; i < NUM_LEDS; i++)
                    store_mode(i, MODE_OFF);
        endcase
        for (int i = 0; i < MASK_LEDS; i++)
            s.lit_mask[i] = led_on[i];
        s.drive_level = (s.lit_mask != 3'd0) ? on_level_q : 8'd0;
        s.selected_mode = (idx < NUM_LEDS) ? led_mode_q[idx] : MODE_OFF;
        s.master_on = master_q;
        return s;
    endfunction

    task automatic send_led_request(input action_t act, input logic [1:0] idx,
                                    input logic [2:0] md, input logic en);
        in_valid <= 1'b1;
        action <= act;
        led_index <= idx;
        new_mode <= md;
        enable_value <= en;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_status_q.push_back(predict_led_status(act, idx, md, en));
        requests_sent++;
        if (sender_calm > 0)
            sender_calm--;
        else if (!sender_quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                sender_calm = $urandom_range(10, 40);
        end
    endtask

    task automatic send_tick(input int count);
        repeat (count)
            send_led_request(ACT_TICK, 2'($urandom_range(0, 3)), 3'($urandom), 1'($urandom));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_led_config(input logic idx, input logic [9:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ON_LEVEL)
            on_level_q = data[7:0];
        else
            pulse_len_q = data;
        @(posedge clk);
    endtask

    task automatic test_reset_readout();
        // out of range index reads mode zero, unused fields ignored
        send_led_request(ACT_TICK, 2'd3, 3'd7, 1'b1);
        send_led_request(ACT_TICK, 2'd0, 3'd0, 1'b0);
    endtask

    task automatic test_mode_writes();
        send_led_request(ACT_SET_MODE, 2'd0, MODE_SOLID, 1'b0);
        send_led_request(ACT_SET_MODE, 2'd1, MODE_PULSE, 1'b1);
        send_led_request(ACT_SET_MODE, 2'd2, MODE_BLINK_5HZ, 1'b0);
        send_led_request(ACT_SET_MODE, 2'd3, MODE_SOLID, 1'b1);
        send_led_request(ACT_TICK, 2'd2, 3'd0, 1'b0);
        send_led_request(ACT_SET_MODE, 2'd0, 3'd6, 1'b0);
        send_led_request(ACT_SET_MODE, 2'd1, 3'd7, 1'b1);
        send_led_request(ACT_SET_MODE, 2'd2, MODE_BLINK_HALF_HZ, 1'b0);
        send_led_request(ACT_SET_MODE, 2'd0, MODE_BLINK_1HZ, 1'b1);
        send_led_request(ACT_TICK, 2'd1, 3'd0, 1'b0);
    endtask

    task automatic test_master_enable();
        send_led_request(ACT_SET_MODE, 2'd1, MODE_SOLID, 1'b0);
        send_led_request(ACT_SET_ENABLE, 2'd0, 3'd0, 1'b0);
        // pulse written while disabled stays unlit and never expires
        send_led_request(ACT_SET_MODE, 2'd2, MODE_PULSE, 1'b0);
        send_led_request(ACT_SET_ENABLE, 2'd1, 3'd7, 1'b1);
        send_led_request(ACT_TICK, 2'd1, 3'd0, 1'b1);
    endtask

    task automatic test_pulse_expiry();
        wait_for_results();
        write_led_config(CFG_PULSE_LEN, 10'd1);
        send_led_request(ACT_SET_MODE, 2'd1, MODE_PULSE, 1'b0);
        send_led_request(ACT_TICK, 2'd1, 3'd0, 1'b0);
        send_led_request(ACT_TICK, 2'd1, 3'd0, 1'b0);
        send_led_request(ACT_TICK, 2'd2, 3'd0, 1'b0);
    endtask

    task automatic test_on_level_zero();
        wait_for_results();
        write_led_config(CFG_ON_LEVEL, 10'd0);
        send_led_request(ACT_SET_MODE, 2'd0, MODE_SOLID, 1'b0);
        send_led_request(ACT_TICK, 2'd0, 3'd0, 1'b0);
    endtask

    task automatic test_all_off();
        send_led_request(ACT_ALL_OFF, 2'd3, 3'd7, 1'b1);
    endtask

    task automatic test_input_backpressure();
        wait_for_results();
        write_led_config(CFG_ON_LEVEL, 10'd77);
        sender_quiet = 1'b1;
        long_hold_req = 1'b1;
        send_led_request(ACT_SET_MODE, 2'd2, MODE_BLINK_5HZ, 1'b0);
        send_led_request(ACT_SET_MODE, 2'd0, MODE_SOLID, 1'b0);
        send_tick(28);
        sender_quiet = 1'b0;
        // sender pauses until everything has drained
        wait_for_results();
    endtask

    task automatic test_long_blink_periods();
        wait_for_results();
        write_led_config(CFG_PULSE_LEN, 10'd300);
        write_led_config(CFG_ON_LEVEL, 10'd170);
        send_led_request(ACT_SET_ENABLE, 2'd0, 3'd0, 1'b1);
        send_led_request(ACT_SET_MODE, 2'd0, MODE_BLINK_1HZ, 1'b0);
        send_led_request(ACT_SET_MODE, 2'd1, MODE_BLINK_HALF_HZ, 1'b0);
        send_led_request(ACT_SET_MODE, 2'd2, MODE_PULSE, 1'b0);
        send_tick(510);
        send_led_request(ACT_SET_MODE, 2'd2, MODE_BLINK_5HZ, 1'b0);
        send_tick(110);
    endtask

    task automatic test_random_traffic();
        int max_burst [4];
        int phase_items;
        int n;
        int pick;
        logic [1:0] idx;
        logic [2:0] md;
        max_burst = '{6, 20, 40, 10};
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_for_results();
            case (ph)
                0:
                begin
                    write_led_config(CFG_ON_LEVEL, 10'd255);
                    write_led_config(CFG_PULSE_LEN, 10'd3);
                end
                1:
                begin
                    write_led_config(CFG_ON_LEVEL, 10'($urandom_range(1, 255)));
                    write_led_config(CFG_PULSE_LEN, 10'd1000);
                end
                2:
                begin
                    write_led_config(CFG_ON_LEVEL, 10'd1);
                    write_led_config(CFG_PULSE_LEN, 10'($urandom_range(1, 60)));
                end
                default:
                begin
                    write_led_config(CFG_ON_LEVEL, 10'($urandom_range(1, 255)));
                    write_led_config(CFG_PULSE_LEN, 10'($urandom_range(1, 20)));
                    sender_quiet = 1'b1;
                    receiver_quiet = 1'b1;
                end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    n = $urandom_range(1, max_burst[ph]);
                    send_tick(n);
                    phase_items += n;
                end
                else if (pick < 82)
                begin
                    idx = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                    md = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5));
                    send_led_request(ACT_SET_MODE, idx, md, 1'($urandom));
                    phase_items++;
                end
                else if (pick < 95)
                begin
                    send_led_request(ACT_SET_ENABLE, 2'($urandom_range(0, 3)), 3'($urandom),
                                     1'($urandom_range(0, 9) < 7));
                    phase_items++;
                end
                else
                begin
                    send_led_request(ACT_ALL_OFF, 2'($urandom_range(0, 3)), 3'($urandom),
                                     1'($urandom));
                    phase_items++;
                end
            end
        end
    endtask

    initial
    begin
        now_ms = 32'd0;
        master_q = 1'b1;
        on_level_q = 8'd1;
        pulse_len_q = 10'd50;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            led_mode_q[i] = MODE_OFF;
            start_ms[i] = 32'd0;
            led_on[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_readout();
        test_mode_writes();
        test_master_enable();
        test_pulse_expiry();
        test_on_level_zero();
        test_all_off();
        test_input_backpressure();
        test_long_blink_periods();
        test_random_traffic();
        wait_for_results();
        error_count += expected_status_q.size();
        $display("led controller run: %0d requests sent, %0d results checked", requests_sent,
                 results_checked);
        $display("modes, enables, all-off, pulse expiry and blink phases over %0d ms", now_ms);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver stalls
    always
    begin
        @(posedge clk);
        if (long_hold_req)
        begin
            out_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            out_stall <= 1'b0;
            long_hold_req = 1'b0;
        end
        else if (receiver_calm > 0)
            receiver_calm--;
        else if (!receiver_quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                receiver_calm = $urandom_range(20, 100);
        end
    end

    always @(posedge clk)
    begin
        led_status_t got;
        led_status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {lit_mask, drive_level, selected_mode, master_on};
            if (expected_status_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no request pending: actual %0h", $time, got);
            end
            else
            begin
                want = expected_status_q.pop_front();
                results_checked++;
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: mismatch expected %0h %0h %0d %0b actual %0h %0h %0d %0b",
                             $time, want.lit_mask, want.drive_level, want.selected_mode,
                             want.master_on, got.lit_mask, got.drive_level,
                             got.selected_mode, got.master_on);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("timeout at %0t with %0d results pending", $time, expected_status_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
